FILE: rtl/ids_pkg.sv
// ----------------------------------------------------------------------------
// ids_pkg: shared types and constants of the indexed deque store.
// Holds operation and status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package ids_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_WORD_WIDTH = 32;

  localparam int KIND_W    = 2;
  localparam int PAYLOAD_W = 32;
  localparam int POS_W     = 8;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_READ_AT    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RESP
  } state_t;

endpackage

FILE: rtl/ids_mod_unit.sv
// ----------------------------------------------------------------------------
// ids_mod_unit: restoring remainder unit for the read position.
// Produces dividend modulo divisor, one quotient bit per cycle, and pulses
// done in the cycle after the last step with the remainder held stable.
// ----------------------------------------------------------------------------
module ids_mod_unit
  import ids_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [POS_W-1:0] dividend,
  input  logic [POS_W-1:0] divisor,
  output logic             done,
  output logic [POS_W-1:0] remainder
);

  localparam int STEP_W = $clog2(POS_W);

  logic              run_r,  run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [POS_W-1:0]  rem_r,  rem_nxt;
  logic [POS_W-1:0]  dvd_r,  dvd_nxt;
  logic [POS_W-1:0]  dsr_r,  dsr_nxt;
  logic [POS_W:0]    shifted;

  assign shifted = {rem_r, dvd_r[POS_W-1]};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (run_r) begin
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = POS_W'(shifted - {1'b0, dsr_r});
      end else begin
        rem_nxt = POS_W'(shifted);
      end
      dvd_nxt  = {dvd_r[POS_W-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(POS_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: rtl/ids_slot_ram.sv
// ----------------------------------------------------------------------------
// ids_slot_ram: slot memory of the deque ring.
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module ids_slot_ram
  import ids_pkg::*;
#(
  parameter int DEPTH  = DEF_CAPACITY,
  parameter int WIDTH  = DEF_WORD_WIDTH,
  parameter int ADDR_W = $clog2(DEF_CAPACITY)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/indexed_deque_store_core.sv
// ----------------------------------------------------------------------------
// indexed_deque_store_core: bounded double-ended word store with indexed read.
//
// An item is taken when start is high and busy is low. Its kind selects push
// front, push back, pop front or read at a 1-based position; a position above
// the count wraps modulo the count, and zero selects the first entry. Every
// item gives one result on the out_ ports, marked by out_valid for exactly one
// cycle; the receiver cannot hold a result off, and the next item may be taken
// while a result is on the ports.
// Pushes and items that end as empty or full show their result in the cycle
// after acceptance and keep busy low, so one such item fits in every cycle.
// A pop or a read without wrap reads the slot memory, whose data is registered,
// and then registers the result on the out_ ports. A read whose position wraps
// first runs the bit-serial remainder unit and waits for its done strobe before
// it reads the slot memory.
// Reset clears the ring pointers and the count; slot contents are left as they
// are and never read before they are written.
// ----------------------------------------------------------------------------
module indexed_deque_store_core
  import ids_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [PAYLOAD_W-1:0] in_payload,
  input  logic [POS_W-1:0]     in_position,
  output logic                 out_valid,
  output logic [DATA_W-1:0]    out_data_out,
  output logic [STATUS_W-1:0]  out_status,
  output logic [COUNT_W-1:0]   out_entry_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int SUM_W = (IDX_W + 1 > POS_W) ? IDX_W + 1 : POS_W + 1;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]    head_r,  head_nxt;
  logic [IDX_W-1:0]    tail_r,  tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  logic                out_valid_r,  out_valid_nxt;
  logic [DATA_W-1:0]   out_data_r,   out_data_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]  out_count_r,  out_count_nxt;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                div_start, div_done;
  logic [POS_W-1:0]    div_rem;

  logic                accept, is_full, is_empty, need_div;
  kind_t               kind;
  logic [IDX_W-1:0]    head_inc, head_dec, tail_inc;

  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] base,
                                               input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] off;
    logic [SUM_W-1:0] sum;
    off = (pos == '0) ? '0 : pos - 1'b1;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign accept   = start && (state_r == ST_IDLE);
  assign kind     = kind_t'(in_kind);
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign need_div = (CMP_W'(in_position) > CMP_W'(count_r));
  assign head_inc = (head_r == IDX_W'(CAPACITY - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? IDX_W'(CAPACITY - 1) : head_r - 1'b1;
  assign tail_inc = (tail_r == IDX_W'(CAPACITY - 1)) ? '0 : tail_r + 1'b1;
  assign ram_wdata = WORD_WIDTH'(in_payload);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !is_empty) begin
          if (kind == OP_POP_FRONT) begin
            state_nxt = ST_RESP;
          end else if (kind == OP_READ_AT) begin
            state_nxt = need_div ? ST_DIV : ST_RESP;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = '0;
    out_status_nxt = STAT_OK;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = tail_r;
    ram_raddr      = head_r;
    div_start      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (kind) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                if (kind == OP_PUSH_FRONT) begin
                  ram_waddr = head_dec;
                  head_nxt  = head_dec;
                end else begin
                  tail_nxt  = tail_inc;
                end
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                head_nxt  = head_inc;
                count_nxt = count_r - 1'b1;
              end
            end
            default: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else if (need_div) begin
                div_start = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = slot_at(head_r, in_position);
              end
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ram_re    = 1'b1;
          ram_raddr = slot_at(head_r, div_rem);
        end
      end
      ST_RESP: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = DATA_W'(ram_rdata);
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
    out_count_nxt = COUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  ids_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_position),
    .divisor   (POS_W'(count_r)),
    .done      (div_done),
    .remainder (div_rem)
  );

  ids_slot_ram #(
    .DEPTH  (CAPACITY),
    .WIDTH  (WORD_WIDTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_data_out    = out_data_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  logic [IDX_W:0] ring_gap;
  assign ring_gap = (tail_r >= head_r) ? {1'b0, tail_r} - {1'b0, head_r}
                                       : {1'b0, tail_r} + (IDX_W+1)'(CAPACITY)
                                         - {1'b0, head_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ring_span: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_W'(CAPACITY)) ? (ring_gap == '0)
                                  : (CNT_W'(ring_gap) == count_r))
    else $error("head, tail and count disagree");

  a_resp_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP) |=> out_valid)
    else $error("read result not presented");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("remainder done outside its wait state");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("slot memory read and written together");

endmodule
